@@ hdl/looped_noise_clip_mixer_defines.svh @@
// ---------------------------------------------------------------------------
// looped_noise_clip_mixer assertion macros
// Shared assertion forms; clk_i and rst_ni must be visible where used.
// ---------------------------------------------------------------------------
`ifndef LOOPED_NOISE_CLIP_MIXER_DEFINES_SVH
`define LOOPED_NOISE_CLIP_MIXER_DEFINES_SVH

// same-cycle implication
`define LNCM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lncm: assertion failed");

// next-cycle implication
`define LNCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lncm: assertion failed");

`endif

@@ hdl/lncm_pkg.sv @@
// ---------------------------------------------------------------------------
// lncm_pkg
// Types and constants shared by the looped noise clip mixer.
// ---------------------------------------------------------------------------
`default_nettype none

package lncm_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int IDX_W          = 16;
  localparam int FRAC_W         = 16;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC_W    = 14;
  localparam int LEN_REGS       = 4;
  localparam int LEN_REG_W      = 15;
  localparam int COUNT_REG_W    = 3;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 15;
  localparam int NUM_CLIPS_DEF  = 4;
  localparam int CLIP_DEPTH_DEF = 16384;

  localparam logic [GAIN_FRAC_W-1:0] GAIN_HALF = GAIN_FRAC_W'(1 << (GAIN_FRAC_W - 1));

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_COUNT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP0_LEN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP3_LEN  = 3'd4;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_MIX  = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e                   req_type;
    logic [1:0]                  load_clip;
    logic [13:0]                 load_addr;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        first_of_clip;
    logic                        noise_en;
    logic [IDX_W-1:0]            clip_choice;
    logic [FRAC_W-1:0]           start_fraction;
    logic [GAIN_W-1:0]           noise_gain;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  mixed_sample;
    logic                        saturated;
  } out_rsp_t;

endpackage

`default_nettype wire

@@ hdl/lncm_store.sv @@
// ---------------------------------------------------------------------------
// lncm_store
// Noise clip store: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module lncm_store #(
  parameter  int DEPTH  = lncm_pkg::NUM_CLIPS_DEF * lncm_pkg::CLIP_DEPTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [ADDR_W-1:0]             waddr_i,
  input  wire logic [lncm_pkg::SAMPLE_W-1:0] wdata_i,
  input  wire logic                          re_i,
  input  wire logic [ADDR_W-1:0]             raddr_i,
  output logic      [lncm_pkg::SAMPLE_W-1:0] rdata_o
);
  import lncm_pkg::*;

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/lncm_mod.sv @@
// ---------------------------------------------------------------------------
// lncm_mod
// Iterative remainder of the clip choice by the clip count, one nibble a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module lncm_mod #(
  parameter  int NUM_CLIPS = lncm_pkg::NUM_CLIPS_DEF,
  localparam int CNT_W     = $clog2(NUM_CLIPS + 1),
  localparam int CLIP_W    = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [lncm_pkg::IDX_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0]           divisor_i,
  output logic                            done_o,
  output logic [CLIP_W-1:0]               rem_o
);
  import lncm_pkg::*;

  localparam int STEPS  = IDX_W / 4;
  localparam int STEP_W = $clog2(STEPS);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [IDX_W-1:0]  sh_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W-1:0]  rem_q, rem_d;

  // restoring remainder over the top nibble
  always_comb begin
    logic [CNT_W:0] trial;
    rem_d = rem_q;
    for (int i = 0; i < 4; i++) begin
      trial = {rem_d, sh_q[IDX_W-1-i]};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      rem_d = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= sh_q << 4;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = CLIP_W'(rem_q);

endmodule

`default_nettype wire

@@ hdl/looped_noise_clip_mixer.sv @@
// ---------------------------------------------------------------------------
// looped_noise_clip_mixer
// Mixes looped noise clips from an on-chip store into a mono audio stream.
// ---------------------------------------------------------------------------
// Usage:
//   in channel (valid/ready) carries load and mix requests; out channel
//   carries one result per mix request, none per load. Config port is a
//   plain write port (clip count, four clip lengths), to be written while
//   idle; the block itself does not enforce this. Load: writes the clip
//   store directly on acceptance; loads can be accepted on consecutive
//   cycles. Mix: the result is registered after the store read, multiply
//   and round steps. With noise off, a first-of-clip mix goes straight to
//   the output register and any other mix skips the store read and
//   multiply. A first-of-clip mix with noise on first has its clip choice
//   reduced by a nibble-serial remainder unit, then the start position is
//   formed by one multiply before the store read; on an empty clip the
//   store read and multiply are skipped. One item is in flight at a time;
//   the input reopens as the result is registered.
//   A finished result sits in the output register; the next request is
//   accepted while it waits. If the receiver stalls with the register
//   full, the following mix holds in its last step until the slot frees.
//   Reset clears control state and latched settings (mixing off); the clip
//   store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module looped_noise_clip_mixer #(
  parameter int NUM_CLIPS  = lncm_pkg::NUM_CLIPS_DEF,
  parameter int CLIP_DEPTH = lncm_pkg::CLIP_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lncm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [lncm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire lncm_pkg::in_req_t               in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output lncm_pkg::out_rsp_t                   out_data_o
);
  import lncm_pkg::*;

  localparam int CLIP_W  = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1;
  localparam int CNT_W   = $clog2(NUM_CLIPS + 1);
  localparam int LEN_W   = $clog2(CLIP_DEPTH + 1);
  localparam int POS_W   = $clog2(CLIP_DEPTH);
  localparam int DEPTH   = NUM_CLIPS * CLIP_DEPTH;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int SPROD_W = LEN_W + FRAC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_START,
    S_ADDR,
    S_MUL,
    S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [COUNT_REG_W-1:0] clip_count_q;
  logic [LEN_REG_W-1:0]   len_q [LEN_REGS];
  logic [CFG_ADDR_W-1:0]  len_sel;

  // latched settings and work registers
  logic                      mixing_on_q, pass_q;
  logic [CLIP_W-1:0]         active_clip_q;
  logic [POS_W-1:0]          pos_q;
  logic [GAIN_W-1:0]         gain_q;
  logic [FRAC_W-1:0]         frac_q;
  logic signed [SAMPLE_W-1:0] s_q;
  logic signed [32:0]        prod_q;
  logic                      out_valid_q;
  out_rsp_t                  out_q;

  logic                 accept, is_mix, mix_on_new, out_free;
  logic [CNT_W-1:0]     eff_cnt;
  logic [LEN_REG_W-1:0] sel_len;
  logic [LEN_W-1:0]     len_cur, pos_eff, pos_inc, pos_nxt;
  logic [SPROD_W-1:0]   start_prod;
  logic [POS_W-1:0]     pos_start;

  logic                 store_we, store_re;
  logic [ADDR_W-1:0]    store_waddr, store_raddr;
  logic [SAMPLE_W-1:0]  store_rdata;
  logic                 mod_start, mod_done;
  logic [CLIP_W-1:0]    mod_rem;

  logic signed [SAMPLE_W-1:0] noise_s;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [34:0]         acc;
  logic signed [20:0]         quo;
  logic [GAIN_FRAC_W-1:0]     frac_bits;
  logic                       round_up;
  logic signed [21:0]         quo_r;
  out_rsp_t                   res;

  assign accept     = in_valid_i && in_ready_o;
  assign is_mix     = (in_data_i.req_type == REQ_MIX);
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  assign eff_cnt    = (32'(clip_count_q) > NUM_CLIPS) ? CNT_W'(NUM_CLIPS)
                                                      : CNT_W'(clip_count_q);
  assign mix_on_new = in_data_i.noise_en && (eff_cnt != '0);

  // effective length of the active clip
  always_comb begin
    sel_len = '0;
    for (int i = 0; i < LEN_REGS; i++) begin
      if (32'(active_clip_q) == i) begin
        sel_len = len_q[i];
      end
    end
  end

  assign len_cur = (32'(sel_len) > CLIP_DEPTH) ? LEN_W'(CLIP_DEPTH) : LEN_W'(sel_len);
  assign pos_eff = (LEN_W'(pos_q) >= len_cur) ? '0 : LEN_W'(pos_q);
  assign pos_inc = pos_eff + 1'b1;
  assign pos_nxt = (pos_inc >= len_cur) ? '0 : pos_inc;

  assign start_prod = SPROD_W'(len_cur) * SPROD_W'(frac_q);
  assign pos_start  = POS_W'(start_prod >> FRAC_W);

  // clip store access
  assign store_we    = accept && !is_mix && (32'(in_data_i.load_clip) < NUM_CLIPS)
                       && (32'(in_data_i.load_addr) < CLIP_DEPTH);
  assign store_waddr = ADDR_W'(32'(in_data_i.load_clip) * CLIP_DEPTH
                               + 32'(in_data_i.load_addr));
  assign store_re    = (state_q == S_ADDR) && mixing_on_q && (len_cur != '0);
  assign store_raddr = ADDR_W'(32'(active_clip_q) * CLIP_DEPTH + 32'(pos_eff));

  assign mod_start = accept && is_mix && in_data_i.first_of_clip && mix_on_new;

  lncm_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (in_data_i.sample),
    .re_i    (store_re),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  lncm_mod #(
    .NUM_CLIPS (NUM_CLIPS)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (in_data_i.clip_choice),
    .divisor_i  (eff_cnt),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // mix arithmetic: Q2.14 gain, round half to even, saturate
  assign noise_s   = $signed(store_rdata);
  assign gain_s    = $signed({1'b0, gain_q});
  assign acc       = $signed({{5{s_q[SAMPLE_W-1]}}, s_q, {GAIN_FRAC_W{1'b0}}}) + 35'(prod_q);
  assign quo       = acc[34:GAIN_FRAC_W];
  assign frac_bits = acc[GAIN_FRAC_W-1:0];
  assign round_up  = (frac_bits > GAIN_HALF) || ((frac_bits == GAIN_HALF) && quo[0]);
  assign quo_r     = 22'(quo) + 22'(round_up);

  always_comb begin
    res.mixed_sample = s_q;
    res.saturated    = 1'b0;
    if (!pass_q) begin
      if (quo_r > 22'sd32767) begin
        res.mixed_sample = 16'sh7fff;
        res.saturated    = 1'b1;
      end else if (quo_r < -22'sd32768) begin
        res.mixed_sample = 16'sh8000;
        res.saturated    = 1'b1;
      end else begin
        res.mixed_sample = quo_r[SAMPLE_W-1:0];
      end
    end
  end

  assign len_sel = cfg_addr_i - REG_CLIP0_LEN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_count_q <= '0;
      for (int i = 0; i < LEN_REGS; i++) begin
        len_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_CLIP_COUNT) begin
        clip_count_q <= cfg_wdata_i[COUNT_REG_W-1:0];
      end else if (cfg_addr_i >= REG_CLIP0_LEN && cfg_addr_i <= REG_CLIP3_LEN) begin
        len_q[len_sel[1:0]] <= cfg_wdata_i[LEN_REG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      mixing_on_q   <= 1'b0;
      active_clip_q <= '0;
      pos_q         <= '0;
      gain_q        <= '0;
      pass_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && is_mix) begin
            if (in_data_i.first_of_clip) begin
              mixing_on_q <= mix_on_new;
              if (mix_on_new) begin
                gain_q  <= in_data_i.noise_gain;
                state_q <= S_MOD;
              end else begin
                pass_q  <= 1'b1;
                state_q <= S_OUT;
              end
            end else begin
              state_q <= S_ADDR;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            active_clip_q <= mod_rem;
            state_q       <= S_START;
          end
        end
        S_START: begin
          pos_q   <= pos_start;
          state_q <= S_ADDR;
        end
        S_ADDR: begin
          if (store_re) begin
            pos_q   <= POS_W'(pos_nxt);
            pass_q  <= 1'b0;
            state_q <= S_MUL;
          end else begin
            pass_q  <= 1'b1;
            state_q <= S_OUT;
          end
        end
        S_MUL: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept && is_mix) begin
      s_q    <= in_data_i.sample;
      frac_q <= in_data_i.start_fraction;
    end
    if (state_q == S_MUL) begin
      prod_q <= noise_s * gain_s;
    end
    if (state_q == S_OUT && out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hdl/lncm_checker.sv @@
// ---------------------------------------------------------------------------
// lncm_checker
// Port-level checks on the mixer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "looped_noise_clip_mixer_defines.svh"

module lncm_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire lncm_pkg::in_req_t  in_data_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire lncm_pkg::out_rsp_t out_data_i
);
  import lncm_pkg::*;

  // a held result keeps its value until taken
  `LNCM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

  // clipping only ever lands on a rail
  `LNCM_ASSERT_IMPL(a_sat_rail, out_valid_i && out_data_i.saturated, out_data_i.mixed_sample == 16'sh7fff || out_data_i.mixed_sample == 16'sh8000)

  // a load transaction leaves the input ready for the next request
  `LNCM_ASSERT_NEXT(a_load_one_cycle, in_valid_i && in_ready_i && in_data_i.req_type == REQ_LOAD, in_ready_i)

  // a mix transaction closes the input after it is accepted
  `LNCM_ASSERT_NEXT(a_mix_busy, in_valid_i && in_ready_i && in_data_i.req_type == REQ_MIX, !in_ready_i)

  // a fresh result coincides with the input reopening
  `LNCM_ASSERT_IMPL(a_out_frees_in, $rose(out_valid_i), in_ready_i)

endmodule

bind looped_noise_clip_mixer lncm_checker u_lncm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire
